>>> src/assert_macros.svh
// Assertion macros shared by the rle_window_decoder RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rle decoder check failed");

// Next-cycle implication, disabled while in reset.
`define RWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rle decoder check failed");

`endif

>>> src/rwd_pkg.sv
// Package for the rle_window_decoder: payload structs, command/status structs
// between controller and datapath, result select and register index codes.
// No dependencies.
`default_nettype none

package rwd_pkg;

    typedef struct packed {
        logic [7:0] comp_byte;
        logic       in_last;
    } rwd_in_t;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [1:0] byte_count;
        logic       out_last;
    } rwd_out_t;

    localparam int unsigned REG_W = 24;

    // configuration register indexes
    localparam logic CFG_READ_OFFSET = 1'b0;
    localparam logic CFG_READ_SIZE   = 1'b1;

    localparam logic [7:0] COUNT_MASK = 8'h7F;

    // result formats
    localparam logic [2:0] RES_EMPTY   = 3'd0; // no bytes, only the end mark
    localparam logic [2:0] RES_LIT     = 3'd1; // literal byte from the input
    localparam logic [2:0] RES_PAIR    = 3'd2; // held run byte plus current one
    localparam logic [2:0] RES_SINGLE  = 3'd3; // current run byte alone
    localparam logic [2:0] RES_PARTIAL = 3'd4; // held run byte alone

    typedef struct packed {
        logic       load_hdr;
        logic       lit_step;
        logic       load_run;
        logic       exp_step;
        logic       pair_load;
        logic       pair_clear;
        logic       clear;
        logic       push;
        logic [2:0] res_sel;
        logic       res_last;
    } rwd_cmd_t;

    typedef struct packed {
        logic fifo_space;
        logic window_full;
        logic emit_ok;
        logic fill_now;
        logic rem_one;
        logic pair_has;
        logic step_any;
        logic run_last;
    } rwd_status_t;

endpackage

`default_nettype wire

>>> src/rwd_datapath.sv
// Datapath of the rle_window_decoder: config registers, decode counters,
// run byte pair buffer and the two-entry result queue.
// Depends on rwd_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rwd_datapath
    import rwd_pkg::*;
#(
    parameter int unsigned POS_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [REG_W-1:0]  cfg_wdata,
    input  wire rwd_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rwd_out_t               out_data,
    input  wire rwd_cmd_t          cmd,
    output rwd_status_t            st
);

    localparam int unsigned CMP_W = (POS_BITS > REG_W) ? POS_BITS : REG_W;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [REG_W-1:0]    read_offset_reg;
    logic [REG_W-1:0]    read_size_reg;
    logic [7:0]          remaining_reg, remaining_next;
    logic [POS_BITS-1:0] position_reg, position_next;
    logic [REG_W-1:0]    emitted_reg, emitted_next;
    logic                window_full_reg, window_full_next;
    logic [7:0]          run_byte_reg;
    logic                run_last_reg;
    logic [7:0]          pair_byte_reg;
    logic                pair_has_reg, pair_has_next;
    logic                step_any_reg, step_any_next;

    rwd_out_t            head_reg, skid_reg;
    logic [1:0]          fifo_cnt_reg;
    rwd_out_t            res;
    logic                pop;
    logic                produce;
    logic [REG_W:0]      emitted_inc;

    // ---------------------------------------------------------------- status
    assign emitted_inc = {1'b0, emitted_reg} + {{REG_W{1'b0}}, 1'b1};
    assign produce     = cmd.lit_step | cmd.exp_step;

    always_comb
    begin
        st.fifo_space  = (fifo_cnt_reg != 2'd2);
        st.window_full = window_full_reg;
        st.emit_ok     = (CMP_W'(position_reg) >= CMP_W'(read_offset_reg))
                       && (emitted_reg < read_size_reg) && !window_full_reg;
        st.fill_now    = st.emit_ok && (emitted_inc >= {1'b0, read_size_reg});
        st.rem_one     = (remaining_reg == 8'd1);
        st.pair_has    = pair_has_reg;
        st.step_any    = step_any_reg;
        st.run_last    = run_last_reg;
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_offset_reg <= '0;
            read_size_reg   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_READ_OFFSET: read_offset_reg <= cfg_wdata;
                CFG_READ_SIZE:   read_size_reg   <= cfg_wdata;
            endcase
        end
    end

    // ---------------------------------------------------------------- decode state
    always_comb
    begin
        remaining_next   = remaining_reg;
        position_next    = position_reg;
        emitted_next     = emitted_reg;
        window_full_next = window_full_reg;
        pair_has_next    = pair_has_reg;
        step_any_next    = step_any_reg;

        if (cmd.load_hdr)
            remaining_next = (in_data.comp_byte & COUNT_MASK) + 8'd1;
        if (produce)
        begin
            remaining_next = remaining_reg - 8'd1;
            if (position_reg != POS_MAX)
                position_next = position_reg + {{(POS_BITS-1){1'b0}}, 1'b1};
            if (st.emit_ok)
            begin
                emitted_next     = emitted_inc[REG_W-1:0];
                window_full_next = st.fill_now;
            end
        end
        if (cmd.load_run)
        begin
            step_any_next = 1'b0;
            pair_has_next = 1'b0;
        end
        if (cmd.exp_step && st.emit_ok)
            step_any_next = 1'b1;
        if (cmd.pair_load)
            pair_has_next = 1'b1;
        if (cmd.pair_clear)
            pair_has_next = 1'b0;
        if (cmd.clear)
        begin
            remaining_next   = '0;
            position_next    = '0;
            emitted_next     = '0;
            window_full_next = 1'b0;
            pair_has_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg   <= '0;
            position_reg    <= '0;
            emitted_reg     <= '0;
            window_full_reg <= 1'b0;
            pair_has_reg    <= 1'b0;
            step_any_reg    <= 1'b0;
            run_last_reg    <= 1'b0;
        end
        else
        begin
            remaining_reg   <= remaining_next;
            position_reg    <= position_next;
            emitted_reg     <= emitted_next;
            window_full_reg <= window_full_next;
            pair_has_reg    <= pair_has_next;
            step_any_reg    <= step_any_next;
            if (cmd.load_run)
                run_last_reg <= in_data.in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_run)
            run_byte_reg <= in_data.comp_byte;
        if (cmd.pair_load)
            pair_byte_reg <= run_byte_reg;
    end

    // ---------------------------------------------------------------- result build
    always_comb
    begin
        res          = '0;
        res.out_last = cmd.res_last;
        unique case (cmd.res_sel)
            RES_EMPTY: ;
            RES_LIT:
            begin
                res.byte_first = in_data.comp_byte;
                res.byte_count = 2'd1;
            end
            RES_PAIR:
            begin
                res.byte_first  = pair_byte_reg;
                res.byte_second = run_byte_reg;
                res.byte_count  = 2'd2;
            end
            RES_SINGLE:
            begin
                res.byte_first = run_byte_reg;
                res.byte_count = 2'd1;
            end
            RES_PARTIAL:
            begin
                res.byte_first = pair_byte_reg;
                res.byte_count = 2'd1;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- result queue
    // head_reg drives the port; skid_reg holds a second result while the head stalls
    assign out_valid = (fifo_cnt_reg != 2'd0);
    assign out_data  = head_reg;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fifo_cnt_reg <= 2'd0;
        else
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, cmd.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (pop && fifo_cnt_reg == 2'd2)
            head_reg <= skid_reg;
        else if (cmd.push && (fifo_cnt_reg == 2'd0 || pop))
            head_reg <= res;
        if (cmd.push && fifo_cnt_reg == 2'd1 && !pop)
            skid_reg <= res;
    end

    `RWD_ASSERT_NOW(a_full_has_bytes, clk, rst_n, window_full_reg, emitted_reg != '0)
    `RWD_ASSERT_NEXT(a_clear_resets, clk, rst_n, cmd.clear,
        position_reg == '0 && emitted_reg == '0 && !window_full_reg)
    `RWD_ASSERT_NOW(a_queue_bound, clk, rst_n, fifo_cnt_reg == 2'd2, !cmd.push)

endmodule

`default_nettype wire

>>> src/rwd_controller.sv
// Controller of the rle_window_decoder: decode phase state machine that
// sequences header, literal and run bytes and the expansion of runs.
// Depends on rwd_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rwd_controller
    import rwd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire rwd_in_t     in_data,
    output rwd_cmd_t         cmd,
    input  wire rwd_status_t st
);

    localparam logic [1:0] ST_HDR  = 2'd0; // expecting header byte
    localparam logic [1:0] ST_RUNB = 2'd1; // expecting run byte
    localparam logic [1:0] ST_LIT  = 2'd2; // in literals
    localparam logic [1:0] ST_EXP  = 2'd3; // expanding a run

    logic [1:0] state_reg, state_next;
    logic       in_fire;
    logic       final_step;

    assign in_stall   = (state_reg == ST_EXP) || !st.fifo_space;
    assign in_fire    = in_valid && !in_stall;
    assign final_step = st.rem_one || st.fill_now;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;

        unique case (state_reg)
            ST_EXP:
            begin
                if (st.fifo_space)
                begin
                    cmd.exp_step = 1'b1;
                    if (st.emit_ok)
                    begin
                        if (st.pair_has)
                        begin
                            cmd.push       = 1'b1;
                            cmd.res_sel    = RES_PAIR;
                            cmd.res_last   = st.fill_now || (st.run_last && st.rem_one);
                            cmd.pair_clear = 1'b1;
                        end
                        else if (final_step)
                        begin
                            cmd.push     = 1'b1;
                            cmd.res_sel  = RES_SINGLE;
                            cmd.res_last = st.fill_now || st.run_last;
                        end
                        else
                            cmd.pair_load = 1'b1;
                    end
                    else if (st.rem_one)
                    begin
                        if (st.pair_has)
                        begin
                            cmd.push       = 1'b1;
                            cmd.res_sel    = RES_PARTIAL;
                            cmd.res_last   = st.run_last;
                            cmd.pair_clear = 1'b1;
                        end
                        else if (st.run_last && !st.step_any)
                        begin
                            cmd.push     = 1'b1;
                            cmd.res_sel  = RES_EMPTY;
                            cmd.res_last = 1'b1;
                        end
                    end
                    // once the window fills the rest of the run cannot emit
                    if (final_step)
                    begin
                        state_next = ST_HDR;
                        cmd.clear  = st.run_last;
                    end
                end
            end
            ST_HDR, ST_RUNB, ST_LIT:
            begin
                if (in_fire)
                begin
                    if (st.window_full)
                    begin
                        if (in_data.in_last)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_HDR;
                        end
                    end
                    else if (state_reg == ST_HDR)
                    begin
                        cmd.load_hdr = 1'b1;
                        state_next   = in_data.comp_byte[7] ? ST_RUNB : ST_LIT;
                        if (in_data.in_last)
                        begin
                            cmd.push     = 1'b1;
                            cmd.res_sel  = RES_EMPTY;
                            cmd.res_last = 1'b1;
                            cmd.clear    = 1'b1;
                            state_next   = ST_HDR;
                        end
                    end
                    else if (state_reg == ST_LIT)
                    begin
                        cmd.lit_step = 1'b1;
                        state_next   = st.rem_one ? ST_HDR : ST_LIT;
                        if (st.emit_ok)
                        begin
                            cmd.push     = 1'b1;
                            cmd.res_sel  = RES_LIT;
                            cmd.res_last = in_data.in_last || st.fill_now;
                        end
                        else if (in_data.in_last)
                        begin
                            cmd.push     = 1'b1;
                            cmd.res_sel  = RES_EMPTY;
                            cmd.res_last = 1'b1;
                        end
                        if (in_data.in_last)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_HDR;
                        end
                    end
                    else
                    begin
                        cmd.load_run = 1'b1;
                        state_next   = ST_EXP;
                    end
                end
            end
            default: state_next = ST_HDR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HDR;
        else
            state_reg <= state_next;
    end

    `RWD_ASSERT_NOW(a_push_has_room, clk, rst_n, cmd.push, st.fifo_space)
    `RWD_ASSERT_NOW(a_exp_not_full, clk, rst_n, state_reg == ST_EXP, !st.window_full)
    `RWD_ASSERT_NOW(a_exp_from_runb, clk, rst_n,
        state_reg == ST_EXP && $past(state_reg) != ST_EXP, $past(state_reg) == ST_RUNB)

endmodule

`default_nettype wire

>>> src/rle_window_decoder.sv
// rle_window_decoder: windowed run-length decoder, top level (controller + datapath).
// Header and literal bytes: taken while the queue has room; a literal result enters the queue.
// Run byte: taken while the queue has room, then expands one decompressed byte per cycle while
// the queue has room, 1 to 128 bytes or until the window fills; byte pairs form one result.
// A two-entry result queue lets the input be taken while one result waits at the output.
// Reset: read_offset 0, read_size all ones, decode state cleared at once; no clearing pass.
`default_nettype none

module rle_window_decoder
    import rwd_pkg::*;
#(
    parameter int unsigned POS_BITS = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [REG_W-1:0] cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire rwd_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output rwd_out_t              out_data
);

    rwd_cmd_t    cmd;
    rwd_status_t st;

    rwd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cmd      (cmd),
        .st       (st)
    );

    rwd_datapath #(
        .POS_BITS (POS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for rle_window_decoder: directed and random compressed streams,
// each checked against a decode predictor kept in the bench, with random stalls on both sides.
// Depends on rwd_pkg and the rle_window_decoder RTL.
module tb;
    import rwd_pkg::*;

    localparam int SETTLE_CYCLES  = 200;   // covers a 128-byte run expanding with nothing emitted
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [REG_W-1:0] REG_ALL_ONES = '1;

    typedef enum logic [1:0] {PH_HEADER, PH_RUN, PH_LITERAL} rle_phase_e;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_READ_OFFSET;
    logic [REG_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    rwd_in_t          in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    rwd_out_t         out_data;

    int tx_idle_pct   = 29;
    int rx_idle_pct   = 45;
    int hold_requests = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int windows_set   = 0;
    int mismatches    = 0;

    // predictor state
    logic [REG_W-1:0] win_offset  = '0;
    logic [REG_W-1:0] win_size    = REG_ALL_ONES;
    rle_phase_e       dec_phase   = PH_HEADER;
    logic [7:0]       dec_left    = '0;
    logic [REG_W-1:0] dec_pos     = '0;
    logic [REG_W-1:0] dec_emitted = '0;
    logic             dec_full    = 1'b0;
    logic [7:0]       step_bytes[$];
    logic             step_filled;
    rwd_out_t         due_results[$];

    rle_window_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial forever #5 clk = ~clk;

    function automatic void clear_decode_state();
        dec_phase   = PH_HEADER;
        dec_left    = '0;
        dec_pos     = '0;
        dec_emitted = '0;
        dec_full    = 1'b0;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        if (dec_pos >= win_offset && dec_emitted < win_size && !dec_full)
        begin
            step_bytes.push_back(b);
            dec_emitted = dec_emitted + 1'b1;
            if (dec_emitted >= win_size)
            begin
                dec_full    = 1'b1;
                step_filled = 1'b1;
            end
        end
        if (dec_pos != REG_ALL_ONES)
            dec_pos = dec_pos + 1'b1;
    endfunction

    // works out the results caused by one compressed byte
    function automatic void rle_expand(input logic [7:0] b, input logic last);
        rwd_out_t res;
        int       i;
        int       n;
        if (dec_full)
        begin
            if (last)
                clear_decode_state();
            return;
        end
        step_bytes.delete();
        step_filled = 1'b0;
        case (dec_phase)
            PH_RUN:
            begin
                for (i = 0; i < dec_left; i++)
                    take_byte(b);
                dec_left  = '0;
                dec_phase = PH_HEADER;
            end
            PH_LITERAL:
            begin
                take_byte(b);
                if (dec_left != 0)
                    dec_left = dec_left - 1'b1;
                if (dec_left == 0)
                    dec_phase = PH_HEADER;
            end
            default:
            begin
                dec_left  = (b & COUNT_MASK) + 8'd1;
                dec_phase = b[7] ? PH_RUN : PH_LITERAL;
            end
        endcase
        n = step_bytes.size();
        for (i = 0; i < n; i += 2)
        begin
            res.byte_first = step_bytes[i];
            if (i + 1 < n)
            begin
                res.byte_second = step_bytes[i + 1];
                res.byte_count  = 2'd2;
            end
            else
            begin
                res.byte_second = '0;
                res.byte_count  = 2'd1;
            end
            res.out_last = (i + 2 >= n) && (last || step_filled);
            due_results.push_back(res);
        end
        if (n == 0 && last)
        begin
            res          = '0;
            res.out_last = 1'b1;
            due_results.push_back(res);
        end
        if (last)
            clear_decode_state();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    endtask

    // offers one byte, holds it until taken, then predicts what it causes
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{comp_byte: b, in_last: last};
        do @(posedge clk); while (in_stall);
        rle_expand(b, last);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [REG_W-1:0] offset, input logic [REG_W-1:0] size);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_READ_OFFSET;
        cfg_wdata <= offset;
        @(posedge clk);
        cfg_index <= CFG_READ_SIZE;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we     <= 1'b0;
        win_offset = offset;
        win_size   = size;
        windows_set++;
    endtask

    // reset window: literals, a maximum-length run, a one-byte literal packet,
    // then a packet cut short on its header
    task automatic test_full_decode();
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h81, 1'b1);
    endtask

    // window fills inside a run; later bytes and the final one give nothing
    task automatic test_window_fill();
        wait_idle();
        set_window(24'd3, 24'd5);
        send_byte(8'h89, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_zero_size();
        wait_idle();
        set_window('0, '0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b1);
    endtask

    // size dropped below the count already emitted, mid-packet
    task automatic test_size_lowered();
        wait_idle();
        set_window('0, REG_ALL_ONES);
        send_byte(8'h03, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        wait_idle();
        set_window('0, 24'd1);
        send_byte(8'h04, 1'b0);
        send_byte(8'h05, 1'b1);
    endtask

    task automatic test_offset_max();
        wait_idle();
        set_window(REG_ALL_ONES, REG_ALL_ONES);
        send_byte(8'h80, 1'b0);
        send_byte(8'h77, 1'b1);
    endtask

    // output held off for a long stretch while runs keep arriving
    task automatic test_output_hold();
        int k;
        wait_idle();
        set_window('0, REG_ALL_ONES);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 6; k++)
        begin
            send_byte(8'h8F, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
        end
        send_byte(8'h01, 1'b0);
        send_byte(8'h9C, 1'b0);
        send_byte(8'h6B, 1'b1);
    endtask

    task automatic pick_window();
        case ($urandom_range(4))
            0: set_window('0, REG_ALL_ONES);
            1: set_window(24'($urandom_range(40)), 24'($urandom_range(1, 60)));
            2: set_window(24'($urandom_range(20)), '0);
            3: set_window(REG_ALL_ONES, 24'($urandom_range(1, 60)));
            default: set_window(24'($urandom_range(10)), REG_ALL_ONES);
        endcase
    endtask

    // mostly well-formed packets; a stray end mark now and then cuts one short
    task automatic send_random_stream(input int len);
        int         sent;
        int         cnt;
        int         body;
        int         k;
        logic [7:0] hdr;
        logic [7:0] b;
        logic       last;
        sent = 0;
        while (sent < len)
        begin
            cnt  = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(5);
            hdr  = {1'($urandom_range(1)), 7'(cnt)};
            body = hdr[7] ? 1 : cnt + 1;
            for (k = 0; k <= body && sent < len; k++)
            begin
                b    = (k == 0) ? hdr : 8'($urandom_range(255));
                last = (sent == len - 1) || ($urandom_range(24) == 0);
                send_byte(b, last);
                sent++;
            end
        end
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int done;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < n_items)
        begin
            wait_idle();
            pick_window();
            len = $urandom_range(8, 14);
            if (len > n_items - done)
                len = n_items - done;
            send_random_stream(len);
            done += len;
        end
    endtask

    initial
    begin : output_side
        int hold_left;
        int seen;
        hold_left = 0;
        seen      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != seen)
            begin
                seen      = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin : result_checker
        rwd_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                results_seen++;
                if (due_results.size() == 0)
                    report_mismatch("transaction with none due, byte_count",
                                    out_data.byte_count, 0);
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.byte_first !== want.byte_first)
                        report_mismatch("byte_first", out_data.byte_first, want.byte_first);
                    if (out_data.byte_second !== want.byte_second)
                        report_mismatch("byte_second", out_data.byte_second, want.byte_second);
                    if (out_data.byte_count !== want.byte_count)
                        report_mismatch("byte_count", out_data.byte_count, want.byte_count);
                    if (out_data.out_last !== want.out_last)
                        report_mismatch("out_last", out_data.out_last, want.out_last);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 quiet, due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_full_decode();
        test_window_fill();
        test_zero_size();
        test_size_lowered();
        test_offset_max();
        test_output_hold();
        run_random_phase(29, 45, 32);
        run_random_phase(45, 29, 32);
        run_random_phase(0, 0, 32);
        wait_idle();
        $display("Decoded %0d compressed bytes into %0d checked results over %0d windows.",
                 bytes_sent, results_seen, windows_set);
        $display("%s%s", "Runs to 128, literals, window fill, empty and lowered windows, ",
                 "cut packets, stalls both ways and a long output hold.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
